@@ rtl/btrl_pkg.sv @@
// ----------------------------------------------------------------------------
// btrl_pkg
// Shared types and codes of the binary trie route lookup.
// ----------------------------------------------------------------------------
package btrl_pkg;

	typedef enum logic [1:0] {
		K_INSERT = 2'd0,
		K_LOOKUP = 2'd1,
		K_REJECT = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] address;
		logic [31:0] mask;
		logic [31:0] gateway;
	} item_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_ZERO_MASK = 2'd2;

endpackage

@@ rtl/btrl_ram.sv @@
// ----------------------------------------------------------------------------
// btrl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module btrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/btrl_front.sv @@
// ----------------------------------------------------------------------------
// btrl_front
// Input side: accepts transactions, classifies them and queues them for the
// trie engine.
// ----------------------------------------------------------------------------
module btrl_front #(
	parameter int PORT_BITS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [31:0]          address,
	input  logic [31:0]          mask,
	input  logic [31:0]          route_next_hop,
	input  logic [PORT_BITS-1:0] route_port,
	output logic                 q_valid,
	input  logic                 q_take,
	output btrl_pkg::item_t      q_item,
	output logic [PORT_BITS-1:0] q_port
);

	btrl_pkg::item_t      item_q [2];
	logic [PORT_BITS-1:0] port_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 push;
	logic                 pop;
	btrl_pkg::item_t      new_item;

	assign in_stall = (count_q == 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign push     = in_valid && !in_stall;
	assign pop      = q_valid && q_take;
	assign q_item   = item_q[rd_ptr_q];
	assign q_port   = port_q[rd_ptr_q];

	always_comb begin
		new_item.address = address;
		new_item.mask    = mask;
		new_item.gateway = route_next_hop;
		if (mode) begin
			new_item.kind = btrl_pkg::K_LOOKUP;
		end else if (mask == 32'd0) begin
			new_item.kind = btrl_pkg::K_REJECT;
		end else begin
			new_item.kind = btrl_pkg::K_INSERT;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q] <= new_item;
			port_q[wr_ptr_q] <= route_port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

endmodule

@@ rtl/btrl_engine.sv @@
// ----------------------------------------------------------------------------
// btrl_engine
// Trie walker: inserts routes and performs longest-prefix lookups, one trie
// level per cycle, and holds the result in an output register.
// ----------------------------------------------------------------------------
module btrl_engine #(
	parameter int NODES     = 4096,
	parameter int PORT_BITS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_take,
	input  btrl_pkg::item_t      q_item,
	input  logic [PORT_BITS-1:0] q_port,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic                 found,
	output logic [31:0]          found_next_hop,
	output logic [PORT_BITS-1:0] found_port
);

	localparam int IDX = $clog2(NODES);
	localparam int RW  = 1 + 32 + PORT_BITS;
	localparam logic [IDX:0] NODES_W = (IDX + 1)'(NODES);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_STEP = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t               state_q;
	logic                 lookup_q;
	logic [IDX-1:0]       node_q;
	logic                 root_q;
	logic                 fresh_q;
	logic [31:0]          path_q;
	logic [31:0]          mask_q;
	logic [31:0]          hop_q;
	logic [PORT_BITS-1:0] port_q;
	logic [IDX-1:0]       root_l_q;
	logic [IDX-1:0]       root_r_q;
	logic [IDX:0]         free_q;
	logic                 best_hit_q;
	logic [31:0]          best_hop_q;
	logic [PORT_BITS-1:0] best_port_q;
	logic [1:0]           res_status_q;
	logic                 res_found_q;
	logic [31:0]          res_hop_q;
	logic [PORT_BITS-1:0] res_port_q;
	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic                 out_found_q;
	logic [31:0]          out_hop_q;
	logic [PORT_BITS-1:0] out_port_q;

	logic                 child_we;
	logic [IDX-1:0]       child_waddr;
	logic [2*IDX-1:0]     child_wdata;
	logic [2*IDX-1:0]     child_rdata;
	logic                 route_we;
	logic [IDX-1:0]       route_waddr;
	logic [RW-1:0]        route_wdata;
	logic [RW-1:0]        route_rdata;
	logic                 rd_en;
	logic [IDX-1:0]       rd_addr;

	logic [IDX-1:0]       cur_l;
	logic [IDX-1:0]       cur_r;
	logic                 dir;
	logic [IDX-1:0]       child;
	logic                 child_none;
	logic                 at_end;
	logic                 is_full;
	logic [IDX-1:0]       alloc_idx;
	logic                 node_hit;
	logic                 hit_nx;
	logic [31:0]          hop_nx;
	logic [PORT_BITS-1:0] port_nx;
	logic                 out_free;

	btrl_ram #(.WIDTH(2 * IDX), .DEPTH(NODES)) u_child_ram (
		.clk   (clk),
		.we    (child_we),
		.waddr (child_waddr),
		.wdata (child_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (child_rdata)
	);

	btrl_ram #(.WIDTH(RW), .DEPTH(NODES)) u_route_ram (
		.clk   (clk),
		.we    (route_we),
		.waddr (route_waddr),
		.wdata (route_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (route_rdata)
	);

	// children of the current node: root in flops, fresh node has none
	always_comb begin
		if (root_q) begin
			cur_l = root_l_q;
			cur_r = root_r_q;
		end else if (fresh_q) begin
			cur_l = '0;
			cur_r = '0;
		end else begin
			cur_l = child_rdata[IDX-1:0];
			cur_r = child_rdata[2*IDX-1:IDX];
		end
	end

	assign dir        = path_q[31];
	assign child      = dir ? cur_r : cur_l;
	assign child_none = (child == '0);
	assign at_end     = (mask_q == 32'd0);
	assign is_full    = (free_q == NODES_W);
	assign alloc_idx  = free_q[IDX-1:0];
	assign node_hit   = !root_q && route_rdata[RW-1];
	assign hit_nx     = best_hit_q || node_hit;
	assign hop_nx     = node_hit ? route_rdata[RW-2 -: 32] : best_hop_q;
	assign port_nx    = node_hit ? route_rdata[PORT_BITS-1:0] : best_port_q;
	assign out_free   = !out_valid_q || !out_stall;
	assign q_take     = (state_q == S_IDLE);

	always_comb begin
		child_we    = 1'b0;
		child_waddr = node_q;
		child_wdata = '0;
		route_we    = 1'b0;
		route_waddr = node_q;
		route_wdata = {1'b1, hop_q, port_q};
		rd_en       = 1'b0;
		rd_addr     = child;
		if (state_q == S_STEP) begin
			if (lookup_q) begin
				rd_en = !at_end && !child_none;
			end else if (at_end) begin
				route_we = 1'b1;
				child_we = fresh_q;
			end else if (!child_none) begin
				rd_en = 1'b1;
			end else if (is_full) begin
				child_we = fresh_q;
			end else begin
				child_we    = !root_q;
				child_wdata = dir ? {alloc_idx, cur_l} : {cur_r, alloc_idx};
				route_we    = 1'b1;
				route_waddr = alloc_idx;
				route_wdata = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) begin
			lookup_q <= (q_item.kind == btrl_pkg::K_LOOKUP);
			path_q   <= (q_item.kind == btrl_pkg::K_LOOKUP) ? q_item.address
				: (q_item.address & q_item.mask);
			mask_q   <= (q_item.kind == btrl_pkg::K_LOOKUP) ? 32'hFFFF_FFFF : q_item.mask;
			hop_q    <= q_item.gateway;
			port_q   <= q_port;
			node_q   <= '0;
		end else if (state_q == S_STEP && !at_end) begin
			path_q <= {path_q[30:0], 1'b0};
			mask_q <= {mask_q[30:0], 1'b0};
			node_q <= child_none ? alloc_idx : child;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			root_q       <= 1'b1;
			fresh_q      <= 1'b0;
			root_l_q     <= '0;
			root_r_q     <= '0;
			free_q       <= (IDX + 1)'(1);
			best_hit_q   <= 1'b0;
			best_hop_q   <= '0;
			best_port_q  <= '0;
			res_status_q <= btrl_pkg::ST_OK;
			res_found_q  <= 1'b0;
			res_hop_q    <= '0;
			res_port_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= btrl_pkg::ST_OK;
			out_found_q  <= 1'b0;
			out_hop_q    <= '0;
			out_port_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						root_q      <= 1'b1;
						fresh_q     <= 1'b0;
						best_hit_q  <= 1'b0;
						best_hop_q  <= '0;
						best_port_q <= '0;
						res_found_q <= 1'b0;
						res_hop_q   <= '0;
						res_port_q  <= '0;
						if (q_item.kind == btrl_pkg::K_REJECT) begin
							res_status_q <= btrl_pkg::ST_ZERO_MASK;
							state_q      <= S_DONE;
						end else begin
							res_status_q <= btrl_pkg::ST_OK;
							state_q      <= S_STEP;
						end
					end
				end
				S_STEP: begin
					if (lookup_q) begin
						best_hit_q  <= hit_nx;
						best_hop_q  <= hop_nx;
						best_port_q <= port_nx;
						if (at_end || child_none) begin
							res_found_q <= hit_nx;
							res_hop_q   <= hop_nx;
							res_port_q  <= port_nx;
							state_q     <= S_DONE;
						end else begin
							root_q <= 1'b0;
						end
					end else if (at_end) begin
						state_q <= S_DONE;
					end else if (!child_none) begin
						root_q  <= 1'b0;
						fresh_q <= 1'b0;
					end else if (is_full) begin
						res_status_q <= btrl_pkg::ST_FULL;
						state_q      <= S_DONE;
					end else begin
						if (root_q && dir) begin
							root_r_q <= alloc_idx;
						end
						if (root_q && !dir) begin
							root_l_q <= alloc_idx;
						end
						free_q  <= free_q + (IDX + 1)'(1);
						root_q  <= 1'b0;
						fresh_q <= 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_found_q  <= res_found_q;
						out_hop_q    <= res_hop_q;
						out_port_q   <= res_port_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign found          = out_found_q;
	assign found_next_hop = out_hop_q;
	assign found_port     = out_port_q;

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= NODES_W && free_q != '0)
		else $error("free node counter out of range");

	a_free_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> free_q >= $past(free_q))
		else $error("free node counter went backwards");

	a_root_not_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STEP |-> !(root_q && fresh_q))
		else $error("root marked as freshly allocated");

	a_err_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != btrl_pkg::ST_OK |-> !out_found_q)
		else $error("failed insert reports a route");

endmodule

@@ rtl/binary_trie_route_lookup.sv @@
// ----------------------------------------------------------------------------
// binary_trie_route_lookup
// IPv4 longest-prefix match on a binary trie with route insertion.
// ----------------------------------------------------------------------------
// Each transaction either inserts a route (mode 0) or looks up a destination
// (mode 1) and gives exactly one result. The engine walks one trie level per
// cycle, reading the child and route stores in parallel. A lookup walks the
// levels it follows, an insert walks its prefix length, and a zero-mask
// insert is rejected without a walk. A two-entry queue at the input and a
// result register at the output let both sides keep moving while a walk is
// in progress. Node stores need no clearing after reset; nodes are
// initialised on allocation.
module binary_trie_route_lookup #(
	parameter int NODES     = 4096,
	parameter int PORT_BITS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [31:0]          address,
	input  logic [31:0]          mask,
	input  logic [31:0]          route_next_hop,
	input  logic [PORT_BITS-1:0] route_port,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic                 found,
	output logic [31:0]          found_next_hop,
	output logic [PORT_BITS-1:0] found_port
);

	logic                 q_valid;
	logic                 q_take;
	btrl_pkg::item_t      q_item;
	logic [PORT_BITS-1:0] q_port;

	btrl_front #(.PORT_BITS(PORT_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.address        (address),
		.mask           (mask),
		.route_next_hop (route_next_hop),
		.route_port     (route_port),
		.q_valid        (q_valid),
		.q_take         (q_take),
		.q_item         (q_item),
		.q_port         (q_port)
	);

	btrl_engine #(.NODES(NODES), .PORT_BITS(PORT_BITS)) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_take         (q_take),
		.q_item         (q_item),
		.q_port         (q_port),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.found          (found),
		.found_next_hop (found_next_hop),
		.found_port     (found_port)
	);

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Binary trie route lookup testbench
// Sends route inserts and destination lookups through the valid/stall
// channels and checks every result against a trie predictor kept in a small
// scoreboard. A directed opening covers the field extremes, masks with holes,
// route overwrites and zero masks. Random traffic follows in four phases with
// different idle and stall rates, with RAND_ITEMS / 4 items in each phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	localparam int          TRIE_NODES  = 4096;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          RAND_ITEMS  = 1450;
	localparam int          POOL_DEPTH  = 64;
	localparam logic        MODE_INSERT = 1'b0;
	localparam logic        MODE_LOOKUP = 1'b1;

	typedef struct {
		logic [1:0]  status;
		logic        found;
		logic [31:0] gw_addr;
		logic [3:0]  port;
	} route_reply_t;

	class route_lookup_board;
		int unsigned  left_kid[TRIE_NODES];
		int unsigned  right_kid[TRIE_NODES];
		bit           holds_route[TRIE_NODES];
		logic [31:0]  route_hop[TRIE_NODES];
		logic [3:0]   route_if[TRIE_NODES];
		int unsigned  next_free;
		route_reply_t awaited_replies[$];
		int           errors, inserts, lookups, hits, full_hits, rejects;

		function new();
			next_free = 1;
		endfunction

		function logic [1:0] insert_route(logic [31:0] addr, logic [31:0] msk,
			logic [31:0] hop, logic [3:0] prt);
			int unsigned tz, len, node, kid;
			logic [31:0] path;
			logic        b;
			if (msk == 32'd0)
				return btrl_pkg::ST_ZERO_MASK;
			tz = 0;
			while (tz < 31 && msk[tz] == 1'b0)
				tz++;
			len  = 32 - tz;
			path = addr & msk;
			node = 0;
			for (int lvl = 0; lvl < len; lvl++) begin
				b   = path[31 - lvl];
				kid = b ? right_kid[node] : left_kid[node];
				if (kid == 0) begin
					if (next_free >= TRIE_NODES)
						return btrl_pkg::ST_FULL;
					kid = next_free;
					next_free++;
					left_kid[kid]    = 0;
					right_kid[kid]   = 0;
					holds_route[kid] = 1'b0;
					if (b)
						right_kid[node] = kid;
					else
						left_kid[node] = kid;
				end
				node = kid;
			end
			holds_route[node] = 1'b1;
			route_hop[node]   = hop;
			route_if[node]    = prt;
			return btrl_pkg::ST_OK;
		endfunction

		function route_reply_t lookup_route(logic [31:0] dest);
			route_reply_t r;
			int unsigned  node, kid;
			r    = '{btrl_pkg::ST_OK, 1'b0, 32'd0, 4'd0};
			node = 0;
			for (int lvl = 0; lvl < 32; lvl++) begin
				kid = dest[31 - lvl] ? right_kid[node] : left_kid[node];
				if (kid == 0)
					break;
				if (holds_route[kid]) begin
					r.found   = 1'b1;
					r.gw_addr = route_hop[kid];
					r.port    = route_if[kid];
				end
				node = kid;
			end
			return r;
		endfunction

		function void note_request(logic m, logic [31:0] addr, logic [31:0] msk,
			logic [31:0] hop, logic [3:0] prt);
			route_reply_t r;
			if (m == MODE_LOOKUP) begin
				r = lookup_route(addr);
				lookups++;
				if (r.found)
					hits++;
			end else begin
				r = '{insert_route(addr, msk, hop, prt), 1'b0, 32'd0, 4'd0};
				inserts++;
				if (r.status == btrl_pkg::ST_FULL)
					full_hits++;
				if (r.status == btrl_pkg::ST_ZERO_MASK)
					rejects++;
			end
			awaited_replies.push_back(r);
		endfunction

		function void check_reply(logic [1:0] st, logic f, logic [31:0] hop,
			logic [3:0] prt);
			route_reply_t e;
			if (awaited_replies.size() == 0) begin
				$error("unexpected result: status %0d found %0d hop %h port %0d",
					st, f, hop, prt);
				errors++;
				return;
			end
			e = awaited_replies.pop_front();
			if (st !== e.status) begin
				$error("status mismatch: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (f !== e.found) begin
				$error("found mismatch: expected %0d, got %0d", e.found, f);
				errors++;
			end
			if (hop !== e.gw_addr) begin
				$error("found_next_hop mismatch: expected %h, got %h", e.gw_addr, hop);
				errors++;
			end
			if (prt !== e.port) begin
				$error("found_port mismatch: expected %0d, got %0d", e.port, prt);
				errors++;
			end
		endfunction

		function int pending();
			return awaited_replies.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [31:0] address;
	logic [31:0] mask;
	logic [31:0] route_next_hop;
	logic [3:0]  route_port;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic        found;
	logic [31:0] found_next_hop;
	logic [3:0]  found_port;

	route_lookup_board board;
	int          src_idle_pct;
	int          snk_stall_pct;
	int          cycles;
	logic [31:0] pool_addr[$];
	logic [31:0] pool_mask[$];

	binary_trie_route_lookup #(
		.NODES    (TRIE_NODES),
		.PORT_BITS(4)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.address       (address),
		.mask          (mask),
		.route_next_hop(route_next_hop),
		.route_port    (route_port),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found         (found),
		.found_next_hop(found_next_hop),
		.found_port    (found_port)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results outstanding",
				cycles, board.pending());
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_request(mode, address, mask, route_next_hop, route_port);
			if (out_valid && !out_stall)
				board.check_reply(status, found, found_next_hop, found_port);
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < snk_stall_pct);
	end

	function automatic logic [31:0] len_mask(int len);
		return 32'hFFFF_FFFF << (32 - len);
	endfunction

	task automatic send_item(logic m, logic [31:0] a, logic [31:0] msk,
		logic [31:0] hop, logic [3:0] prt);
		logic taken;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		mode           <= m;
		address        <= a;
		mask           <= msk;
		route_next_hop <= hop;
		route_port     <= prt;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !in_stall;
			@(negedge clk);
		end
	endtask

	// Inserts mostly grow or overwrite prefixes already in the pool; lookups
	// mostly land under a known prefix so the walks run deep.
	task automatic random_item();
		int          pick, k;
		logic [31:0] a, msk, base_a, base_m;
		pick = $urandom_range(99);
		if (pool_addr.size() > 0) begin
			k      = $urandom_range(pool_addr.size() - 1);
			base_a = pool_addr[k];
			base_m = pool_mask[k];
		end else begin
			base_a = $urandom;
			base_m = len_mask($urandom_range(1, 16));
		end
		if (pick < 45) begin
			a = (pick < 32) ? ((base_a & base_m) | ($urandom & ~base_m)) : $urandom;
			send_item(MODE_LOOKUP, a, $urandom, $urandom, 4'($urandom_range(15)));
		end else begin
			if (pick < 58) begin
				a   = base_a;
				msk = base_m;
			end else if (pick < 78) begin
				msk = len_mask($urandom_range(1, 32));
				a   = (base_a & base_m) | ($urandom & ~base_m);
			end else if (pick < 88) begin
				msk = len_mask($urandom_range(1, 32));
				a   = $urandom;
			end else if (pick < 95) begin
				msk = $urandom;
				a   = $urandom;
			end else begin
				msk = 32'd0;
				a   = $urandom;
			end
			if (msk != 32'd0) begin
				if (pool_addr.size() < POOL_DEPTH) begin
					pool_addr.push_back(a);
					pool_mask.push_back(msk);
				end else begin
					k            = $urandom_range(POOL_DEPTH - 1);
					pool_addr[k] = a;
					pool_mask[k] = msk;
				end
			end
			send_item(MODE_INSERT, a, msk, $urandom, 4'($urandom_range(15)));
		end
	endtask

	task automatic directed_items();
		send_item(MODE_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 4'd0);
		send_item(MODE_INSERT, 32'h0000_0000, 32'h0, 32'h0, 4'd0);
		send_item(MODE_INSERT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 4'd15);
		send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
		send_item(MODE_INSERT, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 4'd15);
		send_item(MODE_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 4'd0);
		send_item(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 4'd5);
		send_item(MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 4'd10);
		send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'd0);
		send_item(MODE_LOOKUP, 32'hFFFF_FFFE, 32'h0, 32'h0, 4'd0);
		send_item(MODE_LOOKUP, 32'h0000_0001, 32'h0, 32'h0, 4'd0);
		send_item(MODE_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 4'd0);
		send_item(MODE_INSERT, 32'h0A00_0000, len_mask(8), 32'h0A00_0001, 4'd3);
		send_item(MODE_INSERT, 32'h0A01_0000, len_mask(16), 32'h0A01_0001, 4'd7);
		send_item(MODE_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 4'd0);
		send_item(MODE_LOOKUP, 32'h0A02_0000, 32'h0, 32'h0, 4'd0);
		// same path again: next hop and port are replaced
		send_item(MODE_INSERT, 32'h0A01_FFFF, len_mask(16), 32'hDEAD_BEEF, 4'd12);
		send_item(MODE_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 4'd0);
		// holed mask: length from the lowest set bit, holes give zero bits
		send_item(MODE_INSERT, 32'hC0A8_0101, 32'hFF00_FF00, 32'hC0A8_00FE, 4'd9);
		send_item(MODE_LOOKUP, 32'hC000_0100, 32'h0, 32'h0, 4'd0);
		send_item(MODE_LOOKUP, 32'hC0A8_0101, 32'h0, 32'h0, 4'd0);
		send_item(MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 4'd1);
		send_item(MODE_LOOKUP, 32'h0000_0001, 32'h0, 32'h0, 4'd0);
		send_item(MODE_INSERT, 32'h5555_5555, 32'h0, 32'hAAAA_AAAA, 4'd6);
	endtask

	initial begin
		int src_pct[4];
		int snk_pct[4];
		src_pct = '{0, 78, 0, 9};
		snk_pct = '{0, 0, 78, 9};
		board          = new();
		src_idle_pct   = 0;
		snk_stall_pct  = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		mode           = MODE_INSERT;
		address        = 32'd0;
		mask           = 32'd0;
		route_next_hop = 32'd0;
		route_port     = 4'd0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_items();
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct  = src_pct[ph];
			snk_stall_pct = snk_pct[ph];
			for (int i = 0; i < RAND_ITEMS / 4; i++)
				random_item();
		end
		in_valid <= 1'b0;

		while (board.pending() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (board.pending() != 0) begin
			$error("%0d results never arrived", board.pending());
			board.errors++;
		end

		$display("Covered %0d inserts (%0d on a full store, %0d zero masks)",
			board.inserts, board.full_hits, board.rejects);
		$display("and %0d lookups (%0d matched); trie nodes in use: %0d of %0d",
			board.lookups, board.hits, board.next_free, TRIE_NODES);
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/btrl_pkg.sv
rtl/btrl_ram.sv
rtl/btrl_front.sv
rtl/btrl_engine.sv
rtl/binary_trie_route_lookup.sv
sim/testbench.sv
